// ===== src/kts_pkg.sv =====
// Shared types, constants and keyword tables for the keyword token scanner.
`timescale 1ns / 1ps

package kts_pkg;

	localparam int LINE_WIDTH   = 16;
	localparam int COLUMN_WIDTH = 12;
	localparam int LENGTH_WIDTH = 8;

	localparam int NUM_KW       = 5;
	localparam int KW_TEXT_W    = 72;
	localparam int ITEM_DEPTH   = 4;
	localparam int RESULT_DEPTH = 4;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_UNDER   = 8'h5F;

	typedef enum logic [3:0] {
		KIND_END       = 4'd0,
		KIND_IDENT     = 4'd1,
		KIND_NUMBER    = 4'd2,
		KIND_RETURN    = 4'd3,
		KIND_DEF       = 4'd4,
		KIND_VAR       = 4'd5,
		KIND_PRINT     = 4'd6,
		KIND_TRANSPOSE = 4'd7,
		KIND_SINGLE    = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_COMMENT
	} mode_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_LETTER,
		CLS_DIGIT,
		CLS_DOT,
		CLS_UNDER,
		CLS_HASH,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		cls_t       cls;
	} item_t;

	// Keyword text, left-justified, zero-padded on the right.
	function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [2:0] kw);
		logic [KW_TEXT_W-1:0] t;
		case (kw)
			3'd0: t = {"return", 24'h0};
			3'd1: t = {"def", 48'h0};
			3'd2: t = {"var", 48'h0};
			3'd3: t = {"print", 32'h0};
			3'd4: t = "transpose";
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] kw, input logic [3:0] pos);
		logic [KW_TEXT_W-1:0] t;
		t = kw_text(kw) << (8 * pos);
		return t[KW_TEXT_W-1 -: 8];
	endfunction

	function automatic logic [3:0] kw_len(input logic [2:0] kw);
		logic [3:0] n;
		case (kw)
			3'd0: n = 4'd6;
			3'd1: n = 4'd3;
			3'd2: n = 4'd3;
			3'd3: n = 4'd5;
			3'd4: n = 4'd9;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic kind_t kw_kind(input logic [2:0] kw);
		kind_t k;
		case (kw)
			3'd0: k = KIND_RETURN;
			3'd1: k = KIND_DEF;
			3'd2: k = KIND_VAR;
			3'd3: k = KIND_PRINT;
			3'd4: k = KIND_TRANSPOSE;
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

endpackage

// ===== src/kts_fifo.sv =====
// Small flip-flop queue with up to two writes and one read per cycle.
`timescale 1ns / 1ps

module kts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en0,
	input  logic [WIDTH-1:0] wr_data0,
	input  logic             wr_en1,
	input  logic [WIDTH-1:0] wr_data1,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full,
	output logic             room_two
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = PW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic [1:0]       wr_num;

	assign wr_num = {1'b0, wr_en0} + {1'b0, wr_en1};

	// second write lands one slot past the first
	always_ff @(posedge clk) begin
		if (wr_en0) mem_q[wr_ptr_q] <= wr_data0;
		if (wr_en1) mem_q[wr_ptr_q + PW'(1)] <= wr_data1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(wr_num);
			rd_ptr_q <= rd_ptr_q + PW'(rd_en);
			count_q  <= count_q + CW'(wr_num) - CW'(rd_en);
		end
	end

	assign rd_data  = mem_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign room_two = (count_q <= CW'(DEPTH - 2));

endmodule

// ===== src/kts_front.sv =====
// Front end: takes source bytes and classifies each into a character class.
`timescale 1ns / 1ps

module kts_front (
	input  logic          push,
	output logic          full,
	input  logic [7:0]    source_byte,
	input  logic          end_of_input,
	input  logic          queue_full,
	output logic          queue_wr,
	output kts_pkg::item_t item
);

	kts_pkg::cls_t cls;

	always_comb begin
		if (source_byte == 8'd32 || (source_byte >= 8'd9 && source_byte <= 8'd13))
			cls = kts_pkg::CLS_SPACE;
		else if ((source_byte >= 8'h61 && source_byte <= 8'h7A) ||
			(source_byte >= 8'h41 && source_byte <= 8'h5A))
			cls = kts_pkg::CLS_LETTER;
		else if (source_byte >= 8'h30 && source_byte <= 8'h39)
			cls = kts_pkg::CLS_DIGIT;
		else if (source_byte == kts_pkg::CHAR_DOT)
			cls = kts_pkg::CLS_DOT;
		else if (source_byte == kts_pkg::CHAR_UNDER)
			cls = kts_pkg::CLS_UNDER;
		else if (source_byte == kts_pkg::CHAR_HASH)
			cls = kts_pkg::CLS_HASH;
		else
			cls = kts_pkg::CLS_OTHER;
	end

	assign full      = queue_full;
	assign queue_wr  = push && !queue_full;
	assign item.data = source_byte;
	assign item.eoi  = end_of_input;
	assign item.cls  = cls;

endmodule

// ===== src/kts_back.sv =====
// Back end: scanner state, keyword matching and token result assembly.
`timescale 1ns / 1ps

module kts_back #(
	parameter int LINE_WIDTH   = kts_pkg::LINE_WIDTH,
	parameter int COLUMN_WIDTH = kts_pkg::COLUMN_WIDTH,
	parameter int LENGTH_WIDTH = kts_pkg::LENGTH_WIDTH,
	localparam int RES_W = 4 + 8 + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kts_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_pop,
	input  logic             room,
	output logic             res_push0,
	output logic [RES_W-1:0] res_data0,
	output logic             res_push1,
	output logic [RES_W-1:0] res_data1
);

	localparam int NK = kts_pkg::NUM_KW;

	kts_pkg::mode_t           mode_q, mode_n;
	logic [NK-1:0]            cand_q, cand_n;
	logic [LENGTH_WIDTH-1:0]  run_q, run_n;
	logic                     ovf_q, ovf_n;
	logic [LINE_WIDTH-1:0]    line_q, line_n;
	logic [COLUMN_WIDTH-1:0]  col_q, col_n;
	logic [LINE_WIDTH-1:0]    sline_q, sline_n;
	logic [COLUMN_WIDTH-1:0]  scol_q, scol_n;

	logic [COLUMN_WIDTH-1:0]  col_pos;
	logic [NK-1:0]            cand_ext, cand_new;
	kts_pkg::kind_t           run_kind;
	logic                     ended, fresh;
	logic [7:0]               b;

	kts_pkg::kind_t           k0, k1;
	logic [7:0]               c0, c1;
	logic [LINE_WIDTH-1:0]    l0, l1;
	logic [COLUMN_WIDTH-1:0]  p0, p1;
	logic [LENGTH_WIDTH-1:0]  n0, n1;
	logic                     o0, o1;

	assign b        = item.data;
	assign item_pop = item_valid && room;
	assign col_pos  = (col_q == '1) ? col_q : col_q + 1'b1;

	always_comb begin
		for (int i = 0; i < NK; i++) begin
			cand_ext[i] = cand_q[i] &&
				(run_q < LENGTH_WIDTH'(kts_pkg::kw_len(3'(i)))) &&
				(kts_pkg::kw_char(3'(i), run_q[3:0]) == b);
			cand_new[i] = (kts_pkg::kw_char(3'(i), 4'd0) == b);
		end
	end

	// lowest keyword index wins
	always_comb begin
		run_kind = (mode_q == kts_pkg::MODE_NUMBER) ? kts_pkg::KIND_NUMBER :
			kts_pkg::KIND_IDENT;
		if (mode_q == kts_pkg::MODE_IDENT && !ovf_q) begin
			for (int i = NK - 1; i >= 0; i--) begin
				if (cand_q[i] && run_q == LENGTH_WIDTH'(kts_pkg::kw_len(3'(i))))
					run_kind = kts_pkg::kw_kind(3'(i));
			end
		end
	end

	always_comb begin
		mode_n  = mode_q;
		cand_n  = cand_q;
		run_n   = run_q;
		ovf_n   = ovf_q;
		line_n  = line_q;
		col_n   = col_q;
		sline_n = sline_q;
		scol_n  = scol_q;
		ended   = 1'b0;
		fresh   = 1'b0;
		res_push0 = 1'b0;
		res_push1 = 1'b0;
		k0 = kts_pkg::KIND_END;  c0 = '0; l0 = '0; p0 = '0; n0 = '0; o0 = 1'b0;
		k1 = kts_pkg::KIND_END;  c1 = '0; l1 = '0; p1 = '0; n1 = '0; o1 = 1'b0;

		if (item_pop) begin
			if (item.eoi) begin
				// flush a pending run, then the end token; return to reset state
				if (mode_q == kts_pkg::MODE_IDENT || mode_q == kts_pkg::MODE_NUMBER) begin
					res_push0 = 1'b1;
					res_push1 = 1'b1;
					k0 = run_kind; l0 = sline_q; p0 = scol_q; n0 = run_q; o0 = ovf_q;
					l1 = line_q;   p1 = col_pos;
				end else begin
					res_push0 = 1'b1;
					l0 = line_q; p0 = col_pos;
				end
				mode_n  = kts_pkg::MODE_IDLE;
				cand_n  = '0;
				run_n   = '0;
				ovf_n   = 1'b0;
				line_n  = LINE_WIDTH'(1);
				col_n   = '0;
				sline_n = LINE_WIDTH'(1);
				scol_n  = '0;
			end else begin
				case (mode_q)
					kts_pkg::MODE_IDENT: begin
						if (item.cls == kts_pkg::CLS_LETTER || item.cls == kts_pkg::CLS_DIGIT ||
							item.cls == kts_pkg::CLS_UNDER) begin
							cand_n = cand_ext;
							ovf_n  = ovf_q | (run_q == '1);
							run_n  = (run_q == '1) ? run_q : run_q + 1'b1;
						end else begin
							ended = 1'b1;
						end
					end
					kts_pkg::MODE_NUMBER: begin
						if (item.cls == kts_pkg::CLS_DIGIT || item.cls == kts_pkg::CLS_DOT) begin
							ovf_n = ovf_q | (run_q == '1);
							run_n = (run_q == '1) ? run_q : run_q + 1'b1;
						end else begin
							ended = 1'b1;
						end
					end
					kts_pkg::MODE_COMMENT: begin
						if (b == kts_pkg::CHAR_NEWLINE) mode_n = kts_pkg::MODE_IDLE;
					end
					default: begin
						fresh = 1'b1;
					end
				endcase

				if (ended) begin
					res_push0 = 1'b1;
					k0 = run_kind; l0 = sline_q; p0 = scol_q; n0 = run_q; o0 = ovf_q;
					mode_n = kts_pkg::MODE_IDLE;
					fresh  = 1'b1;
				end

				// the terminating byte, like any byte taken while idle, may start a token of its own
				if (fresh) begin
					case (item.cls)
						kts_pkg::CLS_SPACE: begin
						end
						kts_pkg::CLS_LETTER: begin
							mode_n  = kts_pkg::MODE_IDENT;
							cand_n  = cand_new;
							run_n   = LENGTH_WIDTH'(1);
							ovf_n   = 1'b0;
							sline_n = line_q;
							scol_n  = col_pos;
						end
						kts_pkg::CLS_DIGIT, kts_pkg::CLS_DOT: begin
							mode_n  = kts_pkg::MODE_NUMBER;
							cand_n  = '0;
							run_n   = LENGTH_WIDTH'(1);
							ovf_n   = 1'b0;
							sline_n = line_q;
							scol_n  = col_pos;
						end
						kts_pkg::CLS_HASH: begin
							mode_n = kts_pkg::MODE_COMMENT;
						end
						default: begin
							if (ended) begin
								res_push1 = 1'b1;
								k1 = kts_pkg::KIND_SINGLE; c1 = b; l1 = line_q; p1 = col_pos;
							end else begin
								res_push0 = 1'b1;
								k0 = kts_pkg::KIND_SINGLE; c0 = b; l0 = line_q; p0 = col_pos;
							end
						end
					endcase
				end

				if (b == kts_pkg::CHAR_NEWLINE) begin
					line_n = (line_q == '1) ? line_q : line_q + 1'b1;
					col_n  = '0;
				end else begin
					col_n = col_pos;
				end
			end
		end

		res_data0 = {k0, c0, l0, p0, n0, o0, !res_push1};
		res_data1 = {k1, c1, l1, p1, n1, o1, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kts_pkg::MODE_IDLE;
			cand_q  <= '0;
			run_q   <= '0;
			ovf_q   <= 1'b0;
			line_q  <= LINE_WIDTH'(1);
			col_q   <= '0;
			sline_q <= LINE_WIDTH'(1);
			scol_q  <= '0;
		end else begin
			mode_q  <= mode_n;
			cand_q  <= cand_n;
			run_q   <= run_n;
			ovf_q   <= ovf_n;
			line_q  <= line_n;
			col_q   <= col_n;
			sline_q <= sline_n;
			scol_q  <= scol_n;
		end
	end

`ifndef SYNTHESIS
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_push1 |-> res_push0)
		else $error("second result pushed without the first");

	a_no_pop_without_room: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> !item_pop)
		else $error("item taken without room for two results");

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.eoi) |=>
		(mode_q == kts_pkg::MODE_IDLE && line_q == LINE_WIDTH'(1) && col_q == '0))
		else $error("scanner not back at reset state after end of input");

	a_comment_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && !item.eoi && mode_q == kts_pkg::MODE_COMMENT) |-> !res_push0)
		else $error("result produced inside a comment");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");
`endif

endmodule

// ===== src/keyword_token_scanner_top.sv =====
// Top level of the keyword token scanner: front, item queue, back, result queue.
`timescale 1ns / 1ps

// Usage:
// Input channel: drive source_byte / end_of_input and raise push; a byte is
// transferred on a clock edge with push high and full low.
// Result channel: while empty is low the oldest token sits on the result ports;
// it is transferred on a clock edge with pop high and empty low.
// Each byte yields zero, one or two tokens; last_result marks the final one.
// end_of_input flushes a pending identifier or number, emits the end token and
// returns the scanner to its power-up state for the next text.
// A token passes from its byte through the item queue, then the scanner, then
// the result queue, whose oldest entry drives the result ports.
// Throughput: one byte per cycle while the scanner is not held off; the
// result port drains one token per cycle, so bursts of two-token bytes fill the
// result queue and then hold off the scanner and, through the item queue, push.
// Reset (arst_n low) empties both queues and clears line to one, column to zero.
// When the receiver stalls, results wait in the result queue; the scanner stops
// when fewer than two slots are free, and full rises once the item queue fills.
module keyword_token_scanner_top #(
	parameter int LINE_WIDTH   = kts_pkg::LINE_WIDTH,
	parameter int COLUMN_WIDTH = kts_pkg::COLUMN_WIDTH,
	parameter int LENGTH_WIDTH = kts_pkg::LENGTH_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              source_byte,
	input  logic                    end_of_input,
	output logic                    empty,
	input  logic                    pop,
	output logic [3:0]              token_kind,
	output logic [7:0]              char_code,
	output logic [LINE_WIDTH-1:0]   start_line,
	output logic [COLUMN_WIDTH-1:0] start_column,
	output logic [LENGTH_WIDTH-1:0] token_length,
	output logic                    length_overflow,
	output logic                    last_result
);

	localparam int RES_W  = 4 + 8 + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 2;
	localparam int ITEM_W = $bits(kts_pkg::item_t);

	kts_pkg::item_t    front_item;
	logic              front_wr;
	logic              item_full;
	logic              item_empty;
	logic [ITEM_W-1:0] item_rd;
	kts_pkg::item_t    back_item;
	logic              item_pop;
	logic              res_room;
	logic              res_push0, res_push1;
	logic [RES_W-1:0]  res_data0, res_data1;
	logic [RES_W-1:0]  res_rd;

	kts_front u_front (
		.push         (push),
		.full         (full),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.queue_full   (item_full),
		.queue_wr     (front_wr),
		.item         (front_item)
	);

	kts_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (kts_pkg::ITEM_DEPTH)
	) u_item_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en0   (front_wr),
		.wr_data0 (front_item),
		.wr_en1   (1'b0),
		.wr_data1 ({ITEM_W{1'b0}}),
		.rd_en    (item_pop),
		.rd_data  (item_rd),
		.empty    (item_empty),
		.full     (item_full),
		.room_two ()
	);

	assign back_item = kts_pkg::item_t'(item_rd);

	kts_back #(
		.LINE_WIDTH   (LINE_WIDTH),
		.COLUMN_WIDTH (COLUMN_WIDTH),
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_valid (!item_empty),
		.item_pop   (item_pop),
		.room       (res_room),
		.res_push0  (res_push0),
		.res_data0  (res_data0),
		.res_push1  (res_push1),
		.res_data1  (res_data1)
	);

	kts_fifo #(
		.WIDTH (RES_W),
		.DEPTH (kts_pkg::RESULT_DEPTH)
	) u_result_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en0   (res_push0),
		.wr_data0 (res_data0),
		.wr_en1   (res_push1),
		.wr_data1 (res_data1),
		.rd_en    (pop && !empty),
		.rd_data  (res_rd),
		.empty    (empty),
		.full     (),
		.room_two (res_room)
	);

	assign {token_kind, char_code, start_line, start_column, token_length,
		length_overflow, last_result} = res_rd;

endmodule
